// ===== rtl/core/imu_gyro_accel_interpolation_sync_unit_assert.svh =====
// Assertion macros for the IMU gyro / accel pairing block.
// Used by the top level; needs clk and arst_n in the including scope.
`ifndef IMU_GYRO_ACCEL_INTERPOLATION_SYNC_UNIT_ASSERT_SVH
`define IMU_GYRO_ACCEL_INTERPOLATION_SYNC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define IGAS_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
`define IGAS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define IGAS_ASSERT_NOW(lbl, pre, post, msg)
`define IGAS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/core/igas_pkg.sv =====
// Shared constants for the IMU gyro / accel pairing block.
// No dependencies.
`timescale 1ns / 1ps
package igas_pkg;
	localparam int ALPHA_BITS = 30;
	localparam int OUT_TIME_W = 48;
	localparam int AXIS_W = 32;
	localparam logic CMD_GYRO = 1'b0;
	localparam logic CMD_ACCEL = 1'b1;
endpackage

// ===== rtl/core/imu_gyro_accel_interpolation_sync_unit.sv =====
// IMU gyro / accel pairing: buffers gyro words, emits them with interpolated accel.
// Depends on igas_pkg and imu_gyro_accel_interpolation_sync_unit_assert.svh.
// A gyro word, or an accel word that starts no run, is taken without blocking. An accel
// word that closes a run of N buffered gyros blocks input until the sink has taken the
// last of its N results, however long it holds m_tready low: each result needs a buffer
// read, a setup step, the bit-serial divider (one quotient bit per cycle, feeding a
// bit-serial shift-add multiplier for the three axes), a rounding step and its output
// handshake. Input and output are never both open in the same cycle.
`timescale 1ns / 1ps
`include "imu_gyro_accel_interpolation_sync_unit_assert.svh"
module imu_gyro_accel_interpolation_sync_unit #(
	parameter int GYRO_DEPTH = 16,
	parameter int TIME_WIDTH = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// sample_time[47:0], axis_x[79:48], axis_y[111:80], axis_z[143:112]
	input  logic [143:0] s_tdata,
	// command
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_time[47:0], rate_x/y/z[143:48], accel_x/y/z[239:144]
	output logic [239:0] m_tdata,
	output logic         m_tlast,
	// overflowed
	output logic         m_tuser
);
	import igas_pkg::*;

	localparam int TW = TIME_WIDTH;
	localparam int IW = (GYRO_DEPTH > 1) ? $clog2(GYRO_DEPTH) : 1;
	localparam int CW = $clog2(GYRO_DEPTH + 1);
	localparam int SW = $clog2(ALPHA_BITS + 1);
	localparam logic signed [63:0] RND = 64'sd1 <<< (ALPHA_BITS - 1);

	typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_LOAD, ST_DIV, ST_FIN, ST_OUT} state_t;

	state_t state_q;
	logic have_q, drop_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] idx_q;
	logic [TW-1:0] prev_time_q, dt_q, rem_q;
	logic signed [31:0] prev_x_q, prev_y_q, prev_z_q, cur_x_q, cur_y_q, cur_z_q;
	logic [TW-1:0] cur_time_q;
	logic signed [32:0] diff_x_q, diff_y_q, diff_z_q;
	logic signed [63:0] acc_x_q, acc_y_q, acc_z_q;
	logic sat_q;
	logic [SW-1:0] step_q;
	logic m_tvalid_q, m_tlast_q, m_tuser_q;
	logic [239:0] out_q;

	logic [TW-1:0] mem_time [GYRO_DEPTH];
	logic [95:0] mem_xyz [GYRO_DEPTH];
	logic [TW-1:0] rd_time_q;
	logic [95:0] rd_xyz_q;

	logic s_accept, gyro_wr;
	logic [TW-1:0] t_in, gdiff;
	logic signed [31:0] x_in, y_in, z_in;
	logic [TW:0] r2, rsub;
	logic qb;
	logic [63:0] gt64;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign t_in = TW'(s_tdata[47:0]);
	assign x_in = s_tdata[79:48];
	assign y_in = s_tdata[111:80];
	assign z_in = s_tdata[143:112];
	assign gyro_wr = s_accept && (s_tuser == CMD_GYRO) && have_q && (cnt_q < CW'(GYRO_DEPTH));
	assign gdiff = rd_time_q - prev_time_q;
	assign r2 = {rem_q, 1'b0};
	assign rsub = r2 - {1'b0, dt_q};
	assign qb = (r2 >= {1'b0, dt_q});
	assign gt64 = 64'(rd_time_q);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = out_q;
	assign m_tlast = m_tlast_q;
	assign m_tuser = m_tuser_q;

	function automatic logic signed [31:0] lerp_round(input logic signed [31:0] a0,
			input logic signed [63:0] p);
		logic signed [63:0] s;
		s = (p + RND) >>> ALPHA_BITS;
		return a0 + s[31:0];
	endfunction

	always_ff @(posedge clk) begin
		if (gyro_wr) begin
			mem_time[cnt_q[IW-1:0]] <= t_in;
			mem_xyz[cnt_q[IW-1:0]] <= s_tdata[143:48];
		end
		if (state_q == ST_READ) begin
			rd_time_q <= mem_time[idx_q];
			rd_xyz_q <= mem_xyz[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			have_q <= 1'b0;
			drop_q <= 1'b0;
			cnt_q <= '0;
			prev_time_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_z_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_accept && s_tuser == CMD_GYRO) begin
						if (have_q) begin
							if (cnt_q < CW'(GYRO_DEPTH)) cnt_q <= cnt_q + 1'b1;
							else drop_q <= 1'b1;
						end
					end else if (s_accept) begin
						if (have_q && t_in > prev_time_q && cnt_q != '0) begin
							cur_time_q <= t_in;
							cur_x_q <= x_in;
							cur_y_q <= y_in;
							cur_z_q <= z_in;
							dt_q <= t_in - prev_time_q;
							diff_x_q <= {x_in[31], x_in} - {prev_x_q[31], prev_x_q};
							diff_y_q <= {y_in[31], y_in} - {prev_y_q[31], prev_y_q};
							diff_z_q <= {z_in[31], z_in} - {prev_z_q[31], prev_z_q};
							idx_q <= '0;
							state_q <= ST_READ;
						end else begin
							have_q <= 1'b1;
							prev_time_q <= t_in;
							prev_x_q <= x_in;
							prev_y_q <= y_in;
							prev_z_q <= z_in;
							cnt_q <= '0;
							drop_q <= 1'b0;
						end
					end
				end
				ST_READ: state_q <= ST_LOAD;
				ST_LOAD: begin
					if (rd_time_q > prev_time_q) begin
						rem_q <= (gdiff > dt_q) ? dt_q : gdiff;
						sat_q <= (gdiff >= dt_q);
					end else begin
						rem_q <= '0;
						sat_q <= 1'b0;
					end
					acc_x_q <= '0;
					acc_y_q <= '0;
					acc_z_q <= '0;
					step_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= qb ? rsub[TW-1:0] : r2[TW-1:0];
					acc_x_q <= (acc_x_q <<< 1) + (qb ? 64'(diff_x_q) : 64'sd0);
					acc_y_q <= (acc_y_q <<< 1) + (qb ? 64'(diff_y_q) : 64'sd0);
					acc_z_q <= (acc_z_q <<< 1) + (qb ? 64'(diff_z_q) : 64'sd0);
					step_q <= step_q + 1'b1;
					if (step_q == SW'(ALPHA_BITS - 1)) state_q <= ST_FIN;
				end
				ST_FIN: begin
					out_q[47:0] <= gt64[47:0];
					out_q[143:48] <= rd_xyz_q;
					out_q[175:144] <= sat_q ? cur_x_q : lerp_round(prev_x_q, acc_x_q);
					out_q[207:176] <= sat_q ? cur_y_q : lerp_round(prev_y_q, acc_y_q);
					out_q[239:208] <= sat_q ? cur_z_q : lerp_round(prev_z_q, acc_z_q);
					m_tlast_q <= (CW'(idx_q) + 1'b1 == cnt_q);
					m_tuser_q <= drop_q;
					m_tvalid_q <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (m_tlast_q) begin
							prev_time_q <= cur_time_q;
							prev_x_q <= cur_x_q;
							prev_y_q <= cur_y_q;
							prev_z_q <= cur_z_q;
							cnt_q <= '0;
							drop_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`IGAS_ASSERT_NOW(a_sides_apart, m_tvalid, !s_tready, "input open while a result waits")
	`IGAS_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= CW'(GYRO_DEPTH), "gyro count past depth")
	`IGAS_ASSERT_NEXT(a_last_frees, m_tvalid && m_tready && m_tlast, s_tready && cnt_q == '0, "run not closed after last word")
endmodule

// ===== dv/tb_top.sv =====
// Testbench for the IMU gyro / accel pairing unit: directed and random sample streams.
// A local predictor builds the expected paired words; needs igas_pkg and the RTL top.
`timescale 1ns / 1ps
module tb_top;
	import igas_pkg::*;

	typedef struct {
		logic cmd;
		logic [47:0] t;
		logic [31:0] x, y, z;
	} sample_t;

	typedef struct {
		logic [239:0] data;
		logic last;
		logic ovf;
	} pair_t;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, s_tuser = 0, m_tready = 0;
	logic [143:0] s_tdata = '0;
	logic s_tready, m_tvalid, m_tlast, m_tuser;
	logic [239:0] m_tdata;

	sample_t pending[$];
	pair_t expected_pairs[$];
	int errors = 0;
	bit stim_done = 0;

	// predictor state
	bit have_acc = 0;
	logic [47:0] acc_t0 = '0;
	logic [31:0] acc0_x = '0, acc0_y = '0, acc0_z = '0;
	sample_t gyro_buf[16];
	int gyro_n = 0;
	bit gyro_lost = 0;

	imu_gyro_accel_interpolation_sync_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	function automatic logic [31:0] blend(logic [31:0] a0, logic [31:0] a1, logic [30:0] alpha);
		longint diff, p, step;
		diff = longint'($signed(a1)) - longint'($signed(a0));
		p = diff * longint'(alpha);
		step = (p + (longint'(1) << 29)) >>> 30;
		return 32'(longint'($signed(a0)) + step);
	endfunction

	task automatic pair_sample(sample_t s);
		logic [47:0] dt, num;
		logic [79:0] q;
		logic [30:0] alpha;
		pair_t r;
		if (s.cmd == CMD_GYRO) begin
			if (!have_acc) return;
			if (gyro_n < 16) begin
				gyro_buf[gyro_n] = s;
				gyro_n++;
			end else begin
				gyro_lost = 1;
			end
			return;
		end
		if (have_acc && s.t > acc_t0) begin
			dt = s.t - acc_t0;
			for (int i = 0; i < gyro_n; i++) begin
				num = '0;
				if (gyro_buf[i].t > acc_t0) begin
					num = gyro_buf[i].t - acc_t0;
					if (num > dt) num = dt;
				end
				if (num >= dt) begin
					alpha = 31'h4000_0000;
				end else begin
					q = {num, 30'b0} / {32'b0, dt};
					alpha = q[30:0];
				end
				r.data = {blend(acc0_z, s.z, alpha), blend(acc0_y, s.y, alpha),
					blend(acc0_x, s.x, alpha), gyro_buf[i].z, gyro_buf[i].y,
					gyro_buf[i].x, gyro_buf[i].t};
				r.last = (i == gyro_n - 1);
				r.ovf = gyro_lost;
				expected_pairs.insert(expected_pairs.size(), r);
			end
		end
		have_acc = 1;
		acc_t0 = s.t;
		acc0_x = s.x;
		acc0_y = s.y;
		acc0_z = s.z;
		gyro_n = 0;
		gyro_lost = 0;
	endtask

	// driver
	int in_gap = 0;
	bit in_burst = 0;
	bit in_fired = 0;
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !in_fired)) begin
			if ($urandom_range(0, 60) == 0) in_burst = !in_burst;
			if (in_gap > 0) begin
				in_gap--;
				s_tvalid <= 0;
			end else if (pending.size() > 0) begin
				sample_t s;
				s = pending[0];
				pending.delete(0);
				s_tvalid <= 1;
				s_tuser <= s.cmd;
				s_tdata <= {s.z, s.y, s.x, s.t};
				if (!in_burst)
					in_gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
						: $urandom_range(5, 40);
			end else begin
				s_tvalid <= 0;
			end
		end
		if (arst_n)
			m_tready <= in_burst ? 1'b1 : ($urandom_range(0, 19) == 0 ? 1'b0
				: ($urandom_range(0, 3) != 0));
	end

	task automatic report(string what, logic [63:0] e, logic [63:0] a);
		$display("%0t mismatch %s expected %h actual %h", $time, what, e, a);
		errors++;
	endtask

	// monitor
	always @(posedge clk) begin
		in_fired = arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			sample_t s;
			s.cmd = s_tuser;
			{s.z, s.y, s.x, s.t} = s_tdata;
			pair_sample(s);
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_pairs.size() == 0) begin
				$display("%0t unexpected word expected none actual %h", $time, m_tdata);
				errors++;
			end else begin
				pair_t e;
				e = expected_pairs[0];
				expected_pairs.delete(0);
				if (e.data[47:0] !== m_tdata[47:0])
					report("out_time", e.data[47:0], m_tdata[47:0]);
				for (int k = 0; k < 6; k++)
					if (e.data[48 + 32 * k +: 32] !== m_tdata[48 + 32 * k +: 32])
						report($sformatf("axis word %0d", k), e.data[48 + 32 * k +: 32],
							m_tdata[48 + 32 * k +: 32]);
				if (e.last !== m_tlast) report("last", e.last, m_tlast);
				if (e.ovf !== m_tuser) report("overflowed", e.ovf, m_tuser);
			end
		end
	end

	task automatic add(logic cmd, logic [47:0] t, logic [31:0] x, logic [31:0] y,
		logic [31:0] z);
		sample_t s;
		s.cmd = cmd;
		s.t = t;
		s.x = x;
		s.y = y;
		s.z = z;
		pending.insert(pending.size(), s);
	endtask

	function automatic logic [31:0] rnd32();
		return $urandom;
	endfunction

	initial begin
		logic [47:0] tcur, dt, gt;
		int k, n_items;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// gyro before any accel, then first accel
		add(CMD_GYRO, 48'd50, 32'h1, 32'h2, 32'h3);
		add(CMD_ACCEL, 48'd100, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
		// in range, before the interval, after the interval, extremes
		add(CMD_GYRO, 48'd150, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
		add(CMD_GYRO, 48'd10, 32'h0, 32'h1234_5678, 32'h8000_0000);
		add(CMD_GYRO, 48'd999, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
		add(CMD_GYRO, 48'd133, rnd32(), rnd32(), rnd32());
		add(CMD_ACCEL, 48'd200, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_0000);
		// accel time not advancing discards the buffer
		add(CMD_GYRO, 48'd250, rnd32(), rnd32(), rnd32());
		add(CMD_ACCEL, 48'd200, rnd32(), rnd32(), rnd32());
		// full buffer
		for (int i = 0; i < 18; i++)
			add(CMD_GYRO, 48'd200 + 48'(i * 3), rnd32(), rnd32(), rnd32());
		add(CMD_ACCEL, 48'hffff_ffff_fffe, rnd32(), rnd32(), rnd32());
		add(CMD_GYRO, 48'hffff_ffff_ffff, rnd32(), rnd32(), rnd32());
		add(CMD_ACCEL, 48'hffff_ffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h1);

		tcur = 48'hffff_ffff_ffff;
		n_items = pending.size();
		while (n_items < 320) begin
			if ($urandom_range(0, 9) == 0) begin
				add(1'($urandom_range(0, 1)), {$urandom, $urandom}, rnd32(), rnd32(),
					rnd32());
				n_items++;
				continue;
			end
			if ($urandom_range(0, 7) == 0) tcur = {$urandom, $urandom};
			dt = ($urandom_range(0, 7) == 0) ? 48'({$urandom, $urandom}) >> $urandom_range(0, 40)
				: 48'($urandom_range(1, 5000));
			k = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
			add(CMD_ACCEL, tcur, rnd32(), rnd32(), rnd32());
			for (int i = 0; i < k; i++) begin
				gt = tcur + 48'(longint'($urandom) % (longint'(dt) + 1));
				if ($urandom_range(0, 7) == 0) gt = {$urandom, $urandom};
				add(CMD_GYRO, gt, rnd32(), rnd32(), rnd32());
			end
			if ($urandom_range(0, 11) != 0) tcur = tcur + dt;
			else tcur = tcur - 48'($urandom_range(0, 3));
			add(CMD_ACCEL, tcur, rnd32(), rnd32(), rnd32());
			n_items += k + 2;
		end

		wait (pending.size() == 0);
		@(posedge clk);
		while (s_tvalid) @(posedge clk);
		while (expected_pairs.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#30ms;
		$display("FAIL");
		$finish;
	end
endmodule

// ===== imu_gyro_accel_interpolation_sync_unit.f =====
+incdir+rtl/core
rtl/core/igas_pkg.sv
rtl/core/imu_gyro_accel_interpolation_sync_unit.sv
dv/tb_top.sv
